### rtl/acfp_pkg.sv
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared types, constants and helpers of the command frame processor.
// ----------------------------------------------------------------------------
package acfp_pkg;

  localparam int unsigned HeaderLen = 48;
  localparam int unsigned LimitW    = 21;
  localparam logic [LimitW-1:0] LimitReset = 21'h100000;

  localparam logic [7:0] MagicBytes [4] = '{8'h5A, 8'h41, 8'h58, 8'h31};

  localparam logic [15:0] OpResult = 16'd1;
  localparam logic [15:0] OpSilent = 16'd2;

  typedef enum logic [1:0] {
    RespAck  = 2'd0,
    RespFail = 2'd1,
    RespOk   = 2'd2
  } resp_type_e;

  typedef enum logic [2:0] {
    FailNone    = 3'd0,
    FailMagic   = 3'd1,
    FailPayload = 3'd2,
    FailHeader  = 3'd3,
    FailOp      = 3'd4
  } fail_code_e;

  // one queue entry: an optional ack followed by an optional second response
  typedef struct packed {
    logic        ack;
    logic        sec;
    resp_type_e  sec_type;
    fail_code_e  sec_code;
    logic [63:0] req;
    logic [63:0] fut;
  } evt_t;

  function automatic evt_t make_finish(logic [63:0] req, logic [63:0] fut,
                                       logic [15:0] op);
    evt_t e;
    e.ack      = (req != 64'd0);
    e.sec      = (op != OpSilent);
    e.sec_type = (op == OpResult) ? RespOk : RespFail;
    e.sec_code = (op == OpResult) ? FailNone : FailOp;
    e.req      = req;
    e.fut      = (op == OpResult) ? fut : 64'd0;
    return e;
  endfunction

  function automatic evt_t make_fail(logic [63:0] req, fail_code_e code);
    evt_t e;
    e.ack      = 1'b0;
    e.sec      = 1'b1;
    e.sec_type = RespFail;
    e.sec_code = code;
    e.req      = req;
    e.fut      = 64'd0;
    return e;
  endfunction

endpackage

### rtl/acfp_front.sv
// ----------------------------------------------------------------------------
// acfp_front
// Byte parser: gathers the header, checks it, skips payload and discarded
// bytes, and hands response events to the queue.
// ----------------------------------------------------------------------------
module acfp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      data_byte_i,
  input  logic                            write_end_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [acfp_pkg::LimitW-1:0]     cfg_data_i,
  input  logic                            evt_full_i,
  output logic                            evt_push_o,
  output acfp_pkg::evt_t                  evt_o
);

  logic [acfp_pkg::LimitW-1:0] limit_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        magic_q, magic_d;
  logic        vk_q, vk_d;
  logic [15:0] op_q, op_d;
  logic [63:0] req_q, req_d;
  logic [63:0] fut_q, fut_d;
  logic [31:0] plen_q, plen_d;
  logic        pay_q, pay_d;
  logic        disc_q, disc_d;
  logic        accept;
  logic [5:0]  off_req, off_fut;
  logic        want;
  acfp_pkg::evt_t evt;
  logic        evt_vld;

  assign in_ready_o  = !evt_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign off_req     = cnt_q - 6'd12;
  assign off_fut     = cnt_q - 6'd36;
  assign want        = (cnt_q == 6'd4) || (cnt_q == 6'd6);

  always_comb begin
    cnt_d   = cnt_q;
    magic_d = magic_q;
    vk_d    = vk_q;
    op_d    = op_q;
    req_d   = req_q;
    fut_d   = fut_q;
    plen_d  = plen_q;
    pay_d   = pay_q;
    disc_d  = disc_q;
    evt     = acfp_pkg::make_finish(req_q, fut_q, op_q);
    evt_vld = 1'b0;
    if (disc_q) begin
      if (write_end_i) disc_d = 1'b0;
    end else if (pay_q) begin
      plen_d = plen_q - 32'd1;
      if (plen_q == 32'd1) begin
        evt_vld = evt.ack || evt.sec;
        pay_d   = 1'b0;
        cnt_d   = '0;
        magic_d = 1'b1;
        vk_d    = 1'b1;
      end
    end else begin
      if (cnt_q < 6'd4) begin
        if (data_byte_i != acfp_pkg::MagicBytes[cnt_q[1:0]]) magic_d = 1'b0;
      end else if (cnt_q < 6'd8) begin
        if (data_byte_i != {7'd0, want}) vk_d = 1'b0;
      end else if (cnt_q < 6'd10) begin
        op_d[{cnt_q[0], 3'b000} +: 8] = data_byte_i;
      end else if (cnt_q >= 6'd12 && cnt_q < 6'd20) begin
        req_d[{off_req[2:0], 3'b000} +: 8] = data_byte_i;
      end else if (cnt_q >= 6'd36 && cnt_q < 6'd44) begin
        fut_d[{off_fut[2:0], 3'b000} +: 8] = data_byte_i;
      end else if (cnt_q >= 6'd44) begin
        plen_d[{cnt_q[1:0], 3'b000} +: 8] = data_byte_i;
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_d == 6'(acfp_pkg::HeaderLen)) begin
        if (!magic_d) begin
          evt     = acfp_pkg::make_fail(64'd0, acfp_pkg::FailMagic);
          evt_vld = 1'b1;
        end else if (plen_d > {11'd0, limit_q}) begin
          evt     = acfp_pkg::make_fail(req_d, acfp_pkg::FailPayload);
          evt_vld = 1'b1;
        end else if (!vk_d) begin
          evt     = acfp_pkg::make_fail(req_d, acfp_pkg::FailHeader);
          evt_vld = 1'b1;
        end else if (plen_d == 32'd0) begin
          evt     = acfp_pkg::make_finish(req_d, fut_d, op_d);
          evt_vld = evt.ack || evt.sec;
        end
        if (evt_vld || plen_d == 32'd0) begin
          cnt_d   = '0;
          magic_d = 1'b1;
          vk_d    = 1'b1;
          disc_d  = evt_vld && (evt.sec_code != acfp_pkg::FailNone) &&
                    (evt.sec_code != acfp_pkg::FailOp) && !write_end_i;
        end else begin
          pay_d = 1'b1;
        end
      end
    end
  end

  assign evt_push_o = accept && evt_vld;
  assign evt_o      = evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= acfp_pkg::LimitReset;
      cnt_q   <= '0;
      magic_q <= 1'b1;
      vk_q    <= 1'b1;
      pay_q   <= 1'b0;
      disc_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (accept) begin
        cnt_q   <= cnt_d;
        magic_q <= magic_d;
        vk_q    <= vk_d;
        pay_q   <= pay_d;
        disc_q  <= disc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_d;
      req_q  <= req_d;
      fut_q  <= fut_d;
      plen_q <= plen_d;
    end
  end

  a_pay_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_q |-> cnt_q == 6'(acfp_pkg::HeaderLen))
    else $error("payload skip outside a complete header");

  a_disc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> !pay_q && cnt_q == 6'd0)
    else $error("discarding with a frame in progress");

endmodule

### rtl/acfp_queue.sv
// ----------------------------------------------------------------------------
// acfp_queue
// Short event queue between the parser and the response sequencer.
// ----------------------------------------------------------------------------
module acfp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  acfp_pkg::evt_t data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output acfp_pkg::evt_t data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  acfp_pkg::evt_t mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + AW'(1);
      if (pop_i)  rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + AW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o |-> !push_i) and (empty_o |-> !pop_i))
    else $error("queue overrun or underrun");

endmodule

### rtl/acfp_back.sv
// ----------------------------------------------------------------------------
// acfp_back
// Response sequencer: turns each queued event into one or two response beats.
// ----------------------------------------------------------------------------
module acfp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  output logic           pop_o,
  input  acfp_pkg::evt_t data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     resp_type_o,
  output logic [63:0]    resp_req_id_o,
  output logic [63:0]    resp_future_id_o,
  output logic [2:0]     fail_code_o,
  output logic           last_resp_o
);

  acfp_pkg::evt_t ev_q;
  logic ev_vld_q;
  logic ack_q;
  logic take;
  logic done;

  assign take  = ev_vld_q && out_ready_i;
  assign done  = take && !(ack_q && ev_q.sec);
  assign pop_o = !empty_i && (!ev_vld_q || done);

  assign out_valid_o      = ev_vld_q;
  assign resp_type_o      = ack_q ? acfp_pkg::RespAck : ev_q.sec_type;
  assign resp_req_id_o    = ev_q.req;
  assign resp_future_id_o = ack_q ? 64'd0 : ev_q.fut;
  assign fail_code_o      = ack_q ? acfp_pkg::FailNone : ev_q.sec_code;
  assign last_resp_o      = !ack_q || !ev_q.sec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q <= 1'b0;
      ack_q    <= 1'b0;
    end else if (pop_o) begin
      ev_vld_q <= 1'b1;
      ack_q    <= data_i.ack;
    end else if (done) begin
      ev_vld_q <= 1'b0;
      ack_q    <= 1'b0;
    end else if (take) begin
      ack_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ev_q <= data_i;
  end

  a_ack_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ack_q |-> resp_req_id_o != 64'd0)
    else $error("ack beat without a request id");

endmodule

### rtl/async_command_frame_processor.sv
// ----------------------------------------------------------------------------
// async_command_frame_processor
// Command frame parser with response descriptors for one command handle.
// ----------------------------------------------------------------------------
// Takes one command byte per cycle. A parser gathers and checks each 48-byte
// header and skips payload and discarded bytes; bytes that end a frame or
// fail a header push at most one event into a queue of QueueDepth entries,
// and a sequencer drains it at one response beat per cycle while the output
// is ready (an ack and a following ok result or fail go out as two beats).
// Input stalls only while the queue is full. No clearing pass after reset.
module async_command_frame_processor #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        write_end_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [acfp_pkg::LimitW-1:0] cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  resp_type_o,
  output logic [63:0]                 resp_req_id_o,
  output logic [63:0]                 resp_future_id_o,
  output logic [2:0]                  fail_code_o,
  output logic                        last_resp_o
);

  acfp_pkg::evt_t push_evt, head_evt;
  logic push, pop, full, empty;

  acfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .write_end_i (write_end_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .evt_full_i  (full),
    .evt_push_o  (push),
    .evt_o       (push_evt)
  );

  acfp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_evt),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (head_evt)
  );

  acfp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .pop_o            (pop),
    .data_i           (head_evt),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .resp_type_o      (resp_type_o),
    .resp_req_id_o    (resp_req_id_o),
    .resp_future_id_o (resp_future_id_o),
    .fail_code_o      (fail_code_o),
    .last_resp_o      (last_resp_o)
  );

endmodule

### tb/async_command_frame_processor_tb.sv
// ----------------------------------------------------------------------------
// async_command_frame_processor_tb
// Feeds command frames, broken headers and noise bytes through the frame
// processor under several payload limits and idle patterns. A scoreboard
// tracks the parser state, predicts every response beat and checks each one.
// ----------------------------------------------------------------------------
module async_command_frame_processor_tb;
  import acfp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseBytes = 32;

  typedef struct {
    resp_type_e  rtype;
    logic [63:0] req;
    logic [63:0] fut;
    fail_code_e  code;
    logic        last;
  } resp_beat_t;

  class frame_scoreboard;
    logic [LimitW-1:0] limit;
    int unsigned       hdr_count;
    bit                magic_good;
    bit                ver_kind_good;
    bit                in_payload;
    bit                discarding;
    logic [15:0]       opcode;
    logic [63:0]       req_id;
    logic [63:0]       fut_id;
    logic [31:0]       remaining;
    resp_beat_t        pending[$];
    int unsigned       errors;
    int unsigned       expected_total;

    function new();
      limit          = LimitReset;
      discarding     = 1'b0;
      errors         = 0;
      expected_total = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      hdr_count     = 0;
      magic_good    = 1'b1;
      ver_kind_good = 1'b1;
      opcode        = '0;
      req_id        = '0;
      fut_id        = '0;
      remaining     = '0;
      in_payload    = 1'b0;
    endfunction

    function bit at_frame_start();
      return hdr_count == 0 && !in_payload && !discarding;
    endfunction

    function void push(resp_type_e t, logic [63:0] r, logic [63:0] f, fail_code_e c);
      resp_beat_t b;
      b.rtype = t;
      b.req   = r;
      b.fut   = f;
      b.code  = c;
      b.last  = 1'b0;
      pending.push_back(b);
      expected_total++;
    endfunction

    function void close_frame();
      if (req_id != 64'd0) push(RespAck, req_id, 64'd0, FailNone);
      if (opcode == OpResult) push(RespOk, req_id, fut_id, FailNone);
      else if (opcode != OpSilent) push(RespFail, req_id, 64'd0, FailOp);
      clear_frame();
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] d, logic w);
      int unsigned n0;
      int unsigned i;
      fail_code_e  code;
      logic [63:0] echo;
      n0 = pending.size();
      if (discarding) begin
        if (w) discarding = 1'b0;
        return;
      end
      if (in_payload) begin
        remaining = remaining - 32'd1;
        if (remaining == 32'd0) close_frame();
      end else begin
        i = hdr_count;
        if (i < 4) begin
          if (d != MagicBytes[i]) magic_good = 1'b0;
        end else if (i < 8) begin
          if (d != ((i == 4 || i == 6) ? 8'd1 : 8'd0)) ver_kind_good = 1'b0;
        end else if (i < 10) begin
          opcode[(i-8)*8 +: 8] = d;
        end else if (i >= 12 && i < 20) begin
          req_id[(i-12)*8 +: 8] = d;
        end else if (i >= 36 && i < 44) begin
          fut_id[(i-36)*8 +: 8] = d;
        end else if (i >= 44 && i < 48) begin
          remaining[(i-44)*8 +: 8] = d;
        end
        hdr_count = i + 1;
        if (hdr_count == HeaderLen) begin
          code = FailNone;
          echo = req_id;
          if (!magic_good) begin
            code = FailMagic;
            echo = 64'd0;
          end else if (remaining > {11'd0, limit}) begin
            code = FailPayload;
          end else if (!ver_kind_good) begin
            code = FailHeader;
          end
          if (code != FailNone) begin
            push(RespFail, echo, 64'd0, code);
            clear_frame();
            discarding = !w;
          end else if (remaining == 32'd0) begin
            close_frame();
          end else begin
            in_payload = 1'b1;
          end
        end
      end
      if (pending.size() > n0) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_resp(logic [1:0] t, logic [63:0] r, logic [63:0] f,
                             logic [2:0] c, logic l);
      resp_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected response beat, resp_type %0d", t);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (t !== e.rtype) begin
        $error("resp_type expected %0d actual %0d", e.rtype, t);
        errors++;
      end
      if (r !== e.req) begin
        $error("resp_req_id expected %h actual %h", e.req, r);
        errors++;
      end
      if (f !== e.fut) begin
        $error("resp_future_id expected %h actual %h", e.fut, f);
        errors++;
      end
      if (c !== e.code) begin
        $error("fail_code expected %0d actual %0d", e.code, c);
        errors++;
      end
      if (l !== e.last) begin
        $error("last_resp expected %0d actual %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        data_byte;
  logic              write_end;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LimitW-1:0] cfg_data;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        resp_type;
  logic [63:0]       resp_req_id;
  logic [63:0]       resp_future_id;
  logic [2:0]        fail_code;
  logic              last_resp;

  frame_scoreboard sb;
  int unsigned     nbytes;
  int unsigned     cycles;
  int unsigned     tx_idle_pct;
  int unsigned     rx_stall_pct;

  async_command_frame_processor u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .write_end_i     (write_end),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .resp_type_o     (resp_type),
    .resp_req_id_o   (resp_req_id),
    .resp_future_id_o(resp_future_id),
    .fail_code_o     (fail_code),
    .last_resp_o     (last_resp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_resp(resp_type, resp_req_id, resp_future_id, fail_code, last_resp);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[async_command_frame_processor] ERROR");
      $finish;
    end
  end

  // called at a falling edge, returns at the next falling edge after the beat
  task automatic put_byte(input logic [7:0] d, input logic w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = d;
    write_end = w;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(d, w);
    nbytes++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // bring the parser back to the start of a header
  task automatic resync();
    while (!sb.at_frame_start()) begin
      if (sb.discarding) put_byte(8'($urandom), 1'b1);
      else if (sb.in_payload) put_byte(8'($urandom), 1'($urandom_range(0, 1)));
      else put_byte(8'h00, 1'b0);
    end
  endtask

  task automatic send_frame(input bit good, input logic [15:0] ver, input logic [15:0] knd,
                            input logic [15:0] op, input logic [63:0] req,
                            input logic [63:0] fut, input logic [31:0] len,
                            input int unsigned npay, input int unsigned cut,
                            input int unsigned wend_pct, input bit end_wend);
    logic [7:0]  hb [HeaderLen];
    int unsigned total;
    logic        w;
    resync();
    foreach (hb[k]) hb[k] = 8'($urandom);
    for (int k = 0; k < 4; k++) hb[k] = MagicBytes[k];
    if (!good) hb[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    hb[4] = ver[7:0];
    hb[5] = ver[15:8];
    hb[6] = knd[7:0];
    hb[7] = knd[15:8];
    hb[8] = op[7:0];
    hb[9] = op[15:8];
    for (int k = 0; k < 8; k++) begin
      hb[12+k] = req[k*8 +: 8];
      hb[36+k] = fut[k*8 +: 8];
    end
    for (int k = 0; k < 4; k++) hb[44+k] = len[k*8 +: 8];
    total = HeaderLen + npay;
    if (cut > 0 && cut < total) total = cut;
    for (int unsigned k = 0; k < total; k++) begin
      w = (k == total - 1) ? end_wend : ($urandom_range(0, 99) < wend_pct);
      put_byte((k < HeaderLen) ? hb[k] : 8'($urandom), w);
    end
  endtask

  task automatic rand_frame();
    int unsigned r;
    int unsigned sel;
    logic [15:0] op;
    logic [15:0] ver;
    logic [15:0] knd;
    logic [63:0] req;
    logic [31:0] len;
    bit          good;
    int unsigned cut;
    r = $urandom_range(0, 99);
    if (r >= 85) begin
      repeat ($urandom_range(1, 40)) put_byte(8'($urandom), $urandom_range(0, 9) == 0);
      return;
    end
    sel = $urandom_range(0, 9);
    if (sel < 4) op = OpResult;
    else if (sel < 7) op = OpSilent;
    else if (sel == 7) op = 16'h0000;
    else if (sel == 8) op = 16'hFFFF;
    else op = 16'($urandom);
    req  = ($urandom_range(0, 4) == 0) ? 64'd0 : {$urandom, $urandom};
    good = 1'b1;
    ver  = 16'd1;
    knd  = 16'd1;
    cut  = 0;
    if (r >= 70) begin
      sel = $urandom_range(0, 3);
      if (sel == 0 || sel == 3) good = 1'b0;
      if (sel == 1 || sel == 3) begin
        ver = 16'($urandom);
        if (ver == 16'd1) ver = 16'd0;
      end
      if (sel == 2) begin
        knd = 16'($urandom);
        if (knd == 16'd1) knd = 16'h0101;
      end
      if ($urandom_range(0, 3) == 0) cut = $urandom_range(1, 43);
    end
    if (sb.limit <= 16 && $urandom_range(0, 4) != 0) begin
      len = $urandom_range(0, sb.limit + 2);
    end else if ($urandom_range(0, 9) == 0) begin
      // always above the limit, so a good header never opens a long payload
      if ($urandom_range(0, 1)) len = 32'hFFFF_FFFF - $urandom_range(0, 255);
      else len = 32'(sb.limit) + 32'd1 + $urandom_range(0, 32'h7FFF_FFFF);
    end else begin
      len = $urandom_range(0, 6);
    end
    send_frame(good, ver, knd, op, req, {$urandom, $urandom}, len,
               (len <= 64) ? len : $urandom_range(0, 3), cut, 8,
               $urandom_range(0, 9) < 7);
  endtask

  initial begin
    logic [LimitW-1:0] phase_limit [7];
    int unsigned       phase_start;
    sb           = new();
    nbytes       = 0;
    cycles       = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    data_byte    = '0;
    write_end    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    out_ready    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed frames at the reset limit
    send_frame(1, 1, 1, OpResult, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0, 1);
    send_frame(1, 1, 1, OpResult, 64'd0, {$urandom, $urandom}, 3, 3, 0, 0, 1);
    send_frame(1, 1, 1, OpSilent, '1, '1, 2, 2, 0, 0, 0);
    send_frame(1, 1, 1, OpSilent, 64'd0, 64'd0, 0, 0, 0, 0, 1);
    send_frame(1, 1, 1, 16'hFFFF, {$urandom, $urandom}, '1, 1, 1, 0, 0, 1);
    send_frame(1, 1, 1, 16'h0000, 64'd0, {$urandom, $urandom}, 0, 0, 0, 0, 1);
    send_frame(0, 1, 1, OpResult, {$urandom, $urandom}, {$urandom, $urandom}, 5, 5, 0, 0, 1);
    send_frame(0, 1, 1, OpResult, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0, 1);
    send_frame(1, 1, 1, OpResult, {$urandom, $urandom}, '1, 0, 0, 0, 0, 1);
    send_frame(1, 1, 1, OpResult, {$urandom, $urandom}, 64'd0, 32'h0010_0001, 2, 0, 0, 1);
    send_frame(1, 1, 1, OpResult, '1, '1, 32'hFFFF_FFFF, 3, 0, 0, 0);
    send_frame(1, 2, 1, OpResult, {$urandom, $urandom}, '1, 1, 2, 0, 0, 1);
    send_frame(1, 1, 0, OpSilent, {$urandom, $urandom}, '1, 0, 0, 0, 0, 1);
    send_frame(1, 16'h0101, 1, OpResult, {$urandom, $urandom}, '1, 0, 0, 0, 0, 0);
    send_frame(1, 1, 16'h8001, OpResult, {$urandom, $urandom}, '1, 0, 0, 0, 0, 1);
    send_frame(0, 7, 1, OpResult, {$urandom, $urandom}, '1, 32'hFFFF_FFFF, 0, 0, 0, 1);
    send_frame(1, 7, 1, OpResult, {$urandom, $urandom}, '1, 32'h0020_0000, 0, 0, 0, 1);
    send_frame(1, 1, 1, OpResult, {$urandom, $urandom}, {$urandom, $urandom}, 8, 8, 0, 50, 0);
    send_frame(1, 1, 1, OpResult, '1, '1, 4, 4, 0, 0, 1);
    send_frame(1, 1, 1, OpResult, {$urandom, $urandom}, '1, 0, 0, 20, 0, 0);
    send_frame(1, 1, 1, OpResult, {$urandom, $urandom}, {$urandom, $urandom}, 0, 0, 0, 0, 1);
    resync();
    settle();

    phase_limit[0] = LimitReset;
    phase_limit[1] = '0;
    phase_limit[2] = '1;
    phase_limit[3] = 21'd3;
    phase_limit[4] = 21'($urandom_range(0, 16));
    phase_limit[5] = LimitReset;
    phase_limit[6] = 21'($urandom);
    for (int p = 0; p < 7; p++) begin
      write_limit(phase_limit[p]);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      phase_start = nbytes;
      while (nbytes < phase_start + PhaseBytes) begin
        rand_frame();
        if ($urandom_range(0, 49) == 0) settle();
      end
      resync();
      settle();
    end

    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[async_command_frame_processor] OK");
    end else begin
      $display("[async_command_frame_processor] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/acfp_pkg.sv
rtl/acfp_front.sv
rtl/acfp_queue.sv
rtl/acfp_back.sv
rtl/async_command_frame_processor.sv
tb/async_command_frame_processor_tb.sv
